FILE: hw/rtl/ospf_interface_dr_election_macros.svh
// ----------------------------------------------------------------------------
// ospf_interface_dr_election_macros.svh
// Assertion shorthands for the DR election block checkers.
// ----------------------------------------------------------------------------
`ifndef OSPF_INTERFACE_DR_ELECTION_MACROS_SVH
`define OSPF_INTERFACE_DR_ELECTION_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ODE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ODE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Checked at every edge, reset included.
`define ODE_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) (expr)) \
      else $error(msg);

`endif

FILE: hw/rtl/ospfdr_pkg.sv
// ----------------------------------------------------------------------------
// ospfdr_pkg
// Shared types and codes for the OSPF interface DR/BDR election block.
// ----------------------------------------------------------------------------
package ospfdr_pkg;

   // Item kinds
   localparam logic [2:0] KIND_NBR_WRITE   = 3'd0;
   localparam logic [2:0] KIND_IF_UP       = 3'd1;
   localparam logic [2:0] KIND_WAIT_TIMER  = 3'd2;
   localparam logic [2:0] KIND_BACKUP_SEEN = 3'd3;
   localparam logic [2:0] KIND_NBR_CHANGE  = 3'd4;

   // Interface modes
   localparam logic [2:0] MODE_DOWN    = 3'd0;
   localparam logic [2:0] MODE_WAITING = 3'd1;
   localparam logic [2:0] MODE_DR      = 3'd2;
   localparam logic [2:0] MODE_BACKUP  = 3'd3;
   localparam logic [2:0] MODE_DROTHER = 3'd4;

   // Register map
   localparam int         CSR_AW            = 4;
   localparam logic [1:0] REG_OWN_ADDRESS   = 2'd0;
   localparam logic [1:0] REG_OWN_ROUTER_ID = 2'd1;
   localparam logic [1:0] REG_OWN_PRIORITY  = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  slot;
      logic        present;
      logic [31:0] nbr_address;
      logic [31:0] nbr_router_id;
      logic [7:0]  nbr_priority;
      logic [31:0] nbr_declared_dr;
      logic [31:0] nbr_declared_bdr;
      logic        nbr_two_way;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  if_mode;
      logic [31:0] dr_address;
      logic [31:0] bdr_address;
      logic        make_router_lsa;
      logic        make_network_lsa;
   } rsp_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] rtr_id;
      logic [7:0]  prio;
      logic [31:0] declared_dr;
      logic [31:0] declared_bdr;
      logic        two_way;
   } nbr_entry_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] rid;
      logic [7:0]  prio;
      logic [31:0] ddr;
      logic [31:0] dbdr;
   } cand_type;

   typedef struct packed {
      logic clear;
      logic load;
   } elect_ctl_type;

   typedef struct packed {
      logic        bdr_found;
      logic [31:0] bdr_addr;
      logic [31:0] dr_addr;
   } elect_res_type;

endpackage

FILE: hw/rtl/ospf_interface_dr_election.sv
// ----------------------------------------------------------------------------
// ospf_interface_dr_election
// OSPF interface DR/BDR election over a neighbor table held in a memory.
// Sequence: an item is decoded in EXEC; a neighbor write or a non-electing event
// then goes to RESP, while an election first runs SELF, SCAN over every slot and
// DONE. RESP holds the word until the output register is free. One item is in
// flight at a time; the table read port, one slot per cycle, sets the scan length.
// Reset: synchronous; empties the table, mode down, DR/BDR 0, priority 1.
// ----------------------------------------------------------------------------
module ospf_interface_dr_election
   import ospfdr_pkg::*;
#(
   parameter int MAX_NEIGHBORS = 16
) (
   input  logic              clock,
   input  logic              reset,
   // item channel
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // Table address width; one bit minimum for a single-entry table.
   localparam int AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

   // One-hot sequencer: decode, seed with self, scan table, resolve, deliver.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_SELF = 6'b000100,
      ST_SCAN = 6'b001000,
      ST_DONE = 6'b010000,
      ST_RESP = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   req_type       req_ff;

   // Interface state
   logic [2:0]    mode_ff, mode_in;
   logic [31:0]   cur_dr_ff, cur_dr_in;
   logic [31:0]   cur_bdr_ff, cur_bdr_in;

   // Result under construction
   logic          acc_ff, acc_in;
   logic          rlsa_ff, rlsa_in;
   logic          nlsa_ff, nlsa_in;

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff;
   logic          rsp_load;
   logic          out_free;

   // Configuration
   logic [31:0]   own_addr_ff, own_addr_in;
   logic [31:0]   own_rid_ff, own_rid_in;
   logic [7:0]    own_prio_ff, own_prio_in;
   logic          csr_wr;

   // Scan and table access
   logic [AW-1:0] scan_idx_ff, scan_idx_in;
   logic [AW-1:0] scan_next;
   logic          scan_last;
   logic [AW+3:0] slot_wide;
   logic          slot_ok;
   logic          wr_en;
   logic [AW-1:0] rd_addr;
   nbr_entry_type wr_entry;
   nbr_entry_type rd_entry;
   logic          rd_valid;

   // Election unit
   elect_ctl_type ctl;
   cand_type      cand;
   cand_type      self_cand;
   cand_type      slot_cand;
   logic          slot_elig;
   elect_res_type res;

   // ------------------------------------------------------------------------
   // Register port: writes land on the access phase; pready is tied high.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      own_addr_in = own_addr_ff;
      own_rid_in  = own_rid_ff;
      own_prio_in = own_prio_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_OWN_ADDRESS:   own_addr_in = csr_pwdata;
            REG_OWN_ROUTER_ID: own_rid_in  = csr_pwdata;
            REG_OWN_PRIORITY:  own_prio_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_OWN_ADDRESS:   csr_prdata = own_addr_ff;
         REG_OWN_ROUTER_ID: csr_prdata = own_rid_ff;
         REG_OWN_PRIORITY:  csr_prdata = {24'd0, own_prio_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Neighbor table. Only one item is in flight, so a slot write never
   // overlaps a scan read and no forwarding is needed.
   // ------------------------------------------------------------------------
   assign slot_wide = {{AW{1'b0}}, req_ff.slot};
   assign slot_ok   = (32'(req_ff.slot) < MAX_NEIGHBORS);

   assign wr_entry.address      = req_ff.nbr_address;
   assign wr_entry.rtr_id       = req_ff.nbr_router_id;
   assign wr_entry.prio         = req_ff.nbr_priority;
   assign wr_entry.declared_dr  = req_ff.nbr_declared_dr;
   assign wr_entry.declared_bdr = req_ff.nbr_declared_bdr;
   assign wr_entry.two_way      = req_ff.nbr_two_way;

   ospfdr_nbr_mem #(
      .DEPTH (MAX_NEIGHBORS),
      .AW    (AW)
   ) u_nbr_mem (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_present (req_ff.present),
      .wr_addr    (slot_wide[AW-1:0]),
      .wr_entry   (wr_entry),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry),
      .rd_valid   (rd_valid)
   );

   // ------------------------------------------------------------------------
   // Candidates: self declares the current DR/BDR; a slot counts only when
   // valid, two-way and with nonzero priority.
   // ------------------------------------------------------------------------
   assign self_cand.addr = own_addr_ff;
   assign self_cand.rid  = own_rid_ff;
   assign self_cand.prio = own_prio_ff;
   assign self_cand.ddr  = cur_dr_ff;
   assign self_cand.dbdr = cur_bdr_ff;

   assign slot_cand.addr = rd_entry.address;
   assign slot_cand.rid  = rd_entry.rtr_id;
   assign slot_cand.prio = rd_entry.prio;
   assign slot_cand.ddr  = rd_entry.declared_dr;
   assign slot_cand.dbdr = rd_entry.declared_bdr;
   assign slot_elig      = rd_valid && rd_entry.two_way && (rd_entry.prio != 8'd0);

   ospfdr_elect u_elect (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .cand  (cand),
      .res   (res)
   );

   assign scan_next = scan_idx_ff + AW'(1);
   assign scan_last = (scan_idx_ff == AW'(MAX_NEIGHBORS - 1));

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      cur_dr_in   = cur_dr_ff;
      cur_bdr_in  = cur_bdr_ff;
      acc_in      = acc_ff;
      rlsa_in     = rlsa_ff;
      nlsa_in     = nlsa_ff;
      scan_idx_in = scan_idx_ff;
      wr_en       = 1'b0;
      rd_addr     = '0;
      ctl         = '0;
      cand        = self_cand;
      rsp_load    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end

         // Decode the item; writes and mode-only events finish here.
         ST_EXEC: begin
            acc_in   = 1'b0;
            rlsa_in  = 1'b0;
            nlsa_in  = 1'b0;
            state_in = ST_RESP;
            case (req_ff.kind)
               KIND_NBR_WRITE: begin
                  acc_in = slot_ok;
                  wr_en  = slot_ok;
               end
               KIND_IF_UP: begin
                  if (mode_ff == MODE_DOWN) begin
                     mode_in = MODE_WAITING;
                     acc_in  = 1'b1;
                  end
               end
               KIND_WAIT_TIMER, KIND_BACKUP_SEEN: begin
                  if (mode_ff == MODE_WAITING) begin
                     acc_in   = 1'b1;
                     state_in = ST_SELF;
                  end
               end
               KIND_NBR_CHANGE: begin
                  if (mode_ff == MODE_DR || mode_ff == MODE_BACKUP ||
                      mode_ff == MODE_DROTHER) begin
                     acc_in   = 1'b1;
                     state_in = ST_SELF;
                  end
               end
               default: ;
            endcase
         end

         // Seed the trackers with self and issue the read of slot 0.
         ST_SELF: begin
            ctl.clear   = 1'b1;
            ctl.load    = 1'b1;
            cand        = self_cand;
            rd_addr     = '0;
            scan_idx_in = '0;
            state_in    = ST_SCAN;
         end

         // Consume slot scan_idx and prefetch the next one.
         ST_SCAN: begin
            cand     = slot_cand;
            ctl.load = slot_elig;
            if (scan_last) begin
               state_in = ST_DONE;
            end else begin
               rd_addr     = scan_next;
               scan_idx_in = scan_next;
            end
         end

         // Commit the election and pick the new mode.
         ST_DONE: begin
            cur_dr_in  = res.dr_addr;
            cur_bdr_in = res.bdr_addr;
            rlsa_in    = 1'b1;
            nlsa_in    = (res.dr_addr == own_addr_ff) && (cur_dr_ff != own_addr_ff);
            if (own_addr_ff == res.dr_addr) begin
               mode_in = MODE_DR;
            end else if (res.bdr_found && own_addr_ff == res.bdr_addr) begin
               mode_in = MODE_BACKUP;
            end else begin
               mode_in = MODE_DROTHER;
            end
            state_in = ST_RESP;
         end

         // Hold until the output register frees up.
         ST_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_DOWN;
         cur_dr_ff    <= '0;
         cur_bdr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         own_addr_ff  <= '0;
         own_rid_ff   <= '0;
         own_prio_ff  <= 8'd1;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cur_dr_ff    <= cur_dr_in;
         cur_bdr_ff   <= cur_bdr_in;
         rsp_valid_ff <= rsp_valid_in;
         own_addr_ff  <= own_addr_in;
         own_rid_ff   <= own_rid_in;
         own_prio_ff  <= own_prio_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      acc_ff      <= acc_in;
      rlsa_ff     <= rlsa_in;
      nlsa_ff     <= nlsa_in;
      scan_idx_ff <= scan_idx_in;
      if (rsp_load) begin
         rsp_data_ff.accepted         <= acc_ff;
         rsp_data_ff.if_mode          <= mode_ff;
         rsp_data_ff.dr_address       <= cur_dr_ff;
         rsp_data_ff.bdr_address      <= cur_bdr_ff;
         rsp_data_ff.make_router_lsa  <= rlsa_ff;
         rsp_data_ff.make_network_lsa <= nlsa_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/ospfdr_nbr_mem.sv
// ----------------------------------------------------------------------------
// ospfdr_nbr_mem
// Neighbor table: one write port, one registered read port, valid flops.
// ----------------------------------------------------------------------------
module ospfdr_nbr_mem
   import ospfdr_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic          wr_present,
   input  logic [AW-1:0] wr_addr,
   input  nbr_entry_type wr_entry,
   input  logic [AW-1:0] rd_addr,
   output nbr_entry_type rd_entry,
   output logic          rd_valid
);

   nbr_entry_type    mem [DEPTH];
   nbr_entry_type    rd_entry_ff;
   logic             rd_valid_ff;
   logic [DEPTH-1:0] valid_ff;

   // Clear only drops the valid bit; data is written on fill.
   always_ff @(posedge clock) begin
      if (wr_en && wr_present) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= wr_present;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

FILE: hw/rtl/ospfdr_elect.sv
// ----------------------------------------------------------------------------
// ospfdr_elect
// Running best trackers for DR, declared BDR and plain BDR candidates.
// ----------------------------------------------------------------------------
module ospfdr_elect
   import ospfdr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  elect_ctl_type ctl,
   input  cand_type      cand,
   output elect_res_type res
);

   localparam int BEST_DR   = 0;
   localparam int BEST_DECL = 1;
   localparam int BEST_ANY  = 2;
   localparam int NBEST     = 3;

   cand_type   best_ff  [NBEST];
   cand_type   best_in  [NBEST];
   logic [NBEST-1:0] found_ff;
   logic [NBEST-1:0] found_in;
   logic [NBEST-1:0] found_eff;
   logic [NBEST-1:0] beats;
   logic [NBEST-1:0] upd;
   logic             is_dr;
   logic             is_bdr;

   assign is_dr  = (cand.ddr == cand.addr);
   assign is_bdr = (cand.dbdr == cand.addr);

   always_comb begin
      for (int k = 0; k < NBEST; k++) begin
         found_eff[k] = found_ff[k] && !ctl.clear;
         // Strictly greater: the earlier candidate keeps a tie.
         beats[k] = {cand.prio, cand.rid} > {best_ff[k].prio, best_ff[k].rid};
      end
      upd[BEST_DR]   = ctl.load && is_dr && (!found_eff[BEST_DR] || beats[BEST_DR]);
      upd[BEST_ANY]  = ctl.load && !is_dr && (!found_eff[BEST_ANY] || beats[BEST_ANY]);
      upd[BEST_DECL] = ctl.load && !is_dr && is_bdr &&
                       (!found_eff[BEST_DECL] || beats[BEST_DECL]);
      for (int k = 0; k < NBEST; k++) begin
         found_in[k] = found_eff[k] || upd[k];
         best_in[k]  = upd[k] ? cand : best_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= '0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NBEST; k++) begin
         best_ff[k] <= best_in[k];
      end
   end

   always_comb begin
      res.bdr_found = found_ff[BEST_DECL] || found_ff[BEST_ANY];
      if (found_ff[BEST_DECL]) begin
         res.bdr_addr = best_ff[BEST_DECL].addr;
      end else if (found_ff[BEST_ANY]) begin
         res.bdr_addr = best_ff[BEST_ANY].addr;
      end else begin
         res.bdr_addr = '0;
      end
      res.dr_addr = found_ff[BEST_DR] ? best_ff[BEST_DR].addr : res.bdr_addr;
   end

endmodule

FILE: hw/rtl/ospfdr_checker.sv
// ----------------------------------------------------------------------------
// ospfdr_checker
// Port-level checks for the DR election block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ospf_interface_dr_election_macros.svh"

module ospfdr_checker
   import ospfdr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `ODE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_data),
                    "result word dropped or changed while stalled")

   `ODE_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready,
                    "second word taken while one is in flight")

   `ODE_ASSERT_IMPL(a_netlsa_dr, rsp_valid && rsp_data.make_network_lsa,
                    rsp_data.make_router_lsa && rsp_data.if_mode == MODE_DR,
                    "network LSA without becoming DR")

   `ODE_ASSERT_IMPL(a_rlsa_elected, rsp_valid && rsp_data.make_router_lsa,
                    rsp_data.accepted && (rsp_data.if_mode == MODE_DR ||
                    rsp_data.if_mode == MODE_BACKUP || rsp_data.if_mode == MODE_DROTHER),
                    "router LSA without a completed election")

   `ODE_ASSERT_ALWAYS(a_reset_quiet, reset || !$past(reset) || !rsp_valid,
                      "result valid right after reset")

endmodule

bind ospf_interface_dr_election ospfdr_checker u_ospfdr_checker (.*);
